>>> rtl/mldf_pkg.sv
// ----------------------------------------------------------------------------
// Multichannel length-prefix deframer package
// Shared constants, field widths and types for the deframer blocks.
// ----------------------------------------------------------------------------
package mldf_pkg;

    localparam int NUM_CHANNELS_DEF = 64;
    localparam int CHAN_W           = 6;
    localparam int BYTE_W           = 8;
    localparam int LEN_W            = 16;

    typedef enum logic [1:0] {
        PH_HIGH    = 2'd0,
        PH_LOW     = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [BYTE_W-1:0]   len_hi;
        logic [LEN_W-1:0]    remaining;
    } t_entry;

    typedef struct packed {
        logic [CHAN_W-1:0]   out_channel;
        logic [BYTE_W-1:0]   out_byte;
        logic                out_last;
        logic                out_empty;
    } t_result;

    typedef struct packed {
        logic                en;
        t_entry              data;
    } t_wr_req;

endpackage

>>> rtl/mldf_if.sv
// ----------------------------------------------------------------------------
// Deframer stream interfaces
// Valid/ready channels for received bytes and for emitted payload bytes.
// ----------------------------------------------------------------------------
interface mldf_in_if;
    logic                           valid;
    logic                           ready;
    logic [mldf_pkg::CHAN_W-1:0]    channel;
    logic [mldf_pkg::BYTE_W-1:0]    data_byte;

    modport source (output valid, output channel, output data_byte, input ready);
    modport sink   (input valid, input channel, input data_byte, output ready);
endinterface

interface mldf_out_if;
    logic                           valid;
    logic                           ready;
    logic [mldf_pkg::CHAN_W-1:0]    out_channel;
    logic [mldf_pkg::BYTE_W-1:0]    out_byte;
    logic                           out_last;
    logic                           out_empty;

    modport source (output valid, output out_channel, output out_byte,
                    output out_last, output out_empty, input ready);
    modport sink   (input valid, input out_channel, input out_byte,
                    input out_last, input out_empty, output ready);
endinterface

>>> rtl/mldf_state_ram.sv
// ----------------------------------------------------------------------------
// Deframer channel state table
// One entry per channel, one write and one registered read per cycle, with a
// clearing sweep after reset that sets every channel to the header phase.
// ----------------------------------------------------------------------------
module mldf_state_ram #(
    parameter int NUM_CHANNELS = mldf_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_rd_en,
    input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] i_rd_addr,
    output mldf_pkg::t_entry                               o_rd_data,
    input  mldf_pkg::t_wr_req                              i_wr,
    input  logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] i_wr_addr,
    output logic                                           o_busy
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_CHANNELS - 1);

    mldf_pkg::t_entry r_mem [NUM_CHANNELS];
    mldf_pkg::t_entry r_rd_data;
    mldf_pkg::t_entry clr_entry;
    logic             r_busy;
    logic [AW-1:0]    r_clr_addr;

    always_comb begin
        clr_entry           = '0;
        clr_entry.phase     = mldf_pkg::PH_HIGH;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= clr_entry;
        end else if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

>>> rtl/mldf_core.sv
// ----------------------------------------------------------------------------
// Deframer decode stage
// Holds the accepted byte, updates its channel's header phase and length
// count, bypasses the last write, and keeps the result register.
// ----------------------------------------------------------------------------
module mldf_core #(
    parameter int NUM_CHANNELS = mldf_pkg::NUM_CHANNELS_DEF
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    mldf_in_if.sink                                        i_in,
    mldf_out_if.source                                     o_out,
    input  logic                                           i_clr_busy,
    output logic                                           o_rd_en,
    output logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] o_rd_addr,
    input  mldf_pkg::t_entry                               i_rd_data,
    output mldf_pkg::t_wr_req                              o_wr,
    output logic [((NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1)-1:0] o_wr_addr
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic                              accept;
    logic [31:0]                       in_ch_ext;
    logic [31:0]                       s1_ch_ext;
    logic                              r_s1_valid;
    logic [mldf_pkg::CHAN_W-1:0]       r_s1_ch;
    logic [mldf_pkg::BYTE_W-1:0]       r_s1_byte;
    logic                              r_wr_valid;
    logic [mldf_pkg::CHAN_W-1:0]       r_wr_ch;
    mldf_pkg::t_entry                  r_wr_data;
    mldf_pkg::t_entry                  cur;
    mldf_pkg::t_entry                  nxt;
    logic [mldf_pkg::LEN_W-1:0]        len;
    logic                              in_range;
    logic                              has_result;
    mldf_pkg::t_result                 res;
    logic                              out_free;
    logic                              s1_adv;
    logic                              r_out_valid;
    mldf_pkg::t_result                 r_out;

    assign in_ch_ext = 32'(i_in.channel);
    assign s1_ch_ext = 32'(r_s1_ch);
    assign in_range  = s1_ch_ext < 32'(NUM_CHANNELS);

    assign out_free    = !r_out_valid || o_out.ready;
    assign s1_adv      = r_s1_valid && (!has_result || out_free);
    assign i_in.ready  = !i_clr_busy && (!r_s1_valid || s1_adv);
    assign accept      = i_in.valid && i_in.ready;

    assign o_rd_en   = accept;
    assign o_rd_addr = in_ch_ext[AW-1:0];
    assign o_wr_addr = s1_ch_ext[AW-1:0];

    always_comb begin
        if (r_wr_valid && (r_wr_ch == r_s1_ch)) begin
            cur = r_wr_data;
        end else begin
            cur = i_rd_data;
        end
    end

    always_comb begin
        nxt             = cur;
        len             = {cur.len_hi, r_s1_byte};
        has_result      = 1'b0;
        res.out_channel = r_s1_ch;
        res.out_byte    = r_s1_byte;
        res.out_last    = 1'b0;
        res.out_empty   = 1'b0;
        case (cur.phase)
            mldf_pkg::PH_LOW: begin
                if (len == '0) begin
                    nxt.phase     = mldf_pkg::PH_HIGH;
                    has_result    = in_range;
                    res.out_byte  = '0;
                    res.out_last  = 1'b1;
                    res.out_empty = 1'b1;
                end else begin
                    nxt.remaining = len;
                    nxt.phase     = mldf_pkg::PH_PAYLOAD;
                end
            end
            mldf_pkg::PH_PAYLOAD: begin
                has_result = in_range;
                if (cur.remaining <= mldf_pkg::LEN_W'(1)) begin
                    res.out_last  = 1'b1;
                    nxt.remaining = '0;
                    nxt.phase     = mldf_pkg::PH_HIGH;
                end else begin
                    nxt.remaining = cur.remaining - mldf_pkg::LEN_W'(1);
                end
            end
            default: begin
                nxt.len_hi = r_s1_byte;
                nxt.phase  = mldf_pkg::PH_LOW;
            end
        endcase
    end

    assign o_wr.en   = s1_adv && in_range;
    assign o_wr.data = nxt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (o_wr.en) begin
                r_wr_valid <= 1'b1;
            end
            if (s1_adv && has_result) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ch   <= i_in.channel;
            r_s1_byte <= i_in.data_byte;
        end
        if (o_wr.en) begin
            r_wr_ch   <= r_s1_ch;
            r_wr_data <= nxt;
        end
        if (s1_adv && has_result) begin
            r_out <= res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_channel = r_out.out_channel;
    assign o_out.out_byte    = r_out.out_byte;
    assign o_out.out_last    = r_out.out_last;
    assign o_out.out_empty   = r_out.out_empty;

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_adv && has_result) |=> r_out_valid)
        else $error("decoded result did not reach the output register");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.out_empty) |-> (r_out.out_last && (r_out.out_byte == '0)))
        else $error("empty marker without last flag or with a data byte");

    a_payload_owes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.en && (nxt.phase == mldf_pkg::PH_PAYLOAD)) |-> (nxt.remaining != '0))
        else $error("payload phase stored with nothing owed");

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clr_busy |=> !r_s1_valid || !$past(i_clr_busy))
        else $error("transaction taken during the clearing sweep");

endmodule

>>> rtl/multichannel_length_prefix_deframer_unit.sv
// ----------------------------------------------------------------------------
// Multichannel length-prefix deframer
// Splits per-channel byte streams into messages with a 16-bit big-endian
// length header and emits each payload byte with its channel and last flag.
// ----------------------------------------------------------------------------
// The block accepts one byte transaction per clock while the output is not
// held back and the clearing sweep is over. Each payload byte passes the
// stage register and the result register; a zero-length message gives a
// single transaction flagged empty and last. The channel state table, read
// when a byte is taken and written when it leaves the stage register, sets
// the rate; a one-entry bypass of the latest write lets bytes of the same
// channel follow each other in consecutive cycles. After reset the table is
// swept clear, one channel per cycle, with input ready low until it ends.
module multichannel_length_prefix_deframer_unit #(
    parameter int NUM_CHANNELS = mldf_pkg::NUM_CHANNELS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mldf_in_if.sink    i_in,
    mldf_out_if.source o_out
);

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    mldf_pkg::t_entry  rd_data;
    mldf_pkg::t_wr_req wr;
    logic [AW-1:0]     wr_addr;
    logic              clr_busy;

    mldf_state_ram #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_state_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr      (wr),
        .i_wr_addr (wr_addr),
        .o_busy    (clr_busy)
    );

    mldf_core #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_clr_busy (clr_busy),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr       (wr),
        .o_wr_addr  (wr_addr)
    );

endmodule

>>> test/mldf_deframe_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deframer payload checker
// Watches the byte input and the payload output of the deframer and keeps
// its own per-channel header state. Every accepted input byte updates that
// state, and each byte that should come out is queued. Every output
// transaction is checked field by field against the oldest queued byte.
// The checker reports its mismatch count and the number of queued bytes.
// ----------------------------------------------------------------------------
module mldf_deframe_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mldf_in_if   rx_mon,
    mldf_out_if  tx_mon,
    output int   o_mismatches,
    output int   o_outstanding
);
    import mldf_pkg::*;

    t_phase            chan_phase  [NUM_CHANNELS_DEF];
    logic [BYTE_W-1:0] chan_len_hi [NUM_CHANNELS_DEF];
    logic [LEN_W-1:0]  chan_left   [NUM_CHANNELS_DEF];
    t_result           payload_q   [$];
    int                mismatch_count = 0;

    function automatic bit deframe_byte(input logic [CHAN_W-1:0] ch,
                                        input logic [BYTE_W-1:0] b,
                                        output t_result res);
        logic [LEN_W-1:0] len;
        res = '0;
        len = {chan_len_hi[ch], b};
        case (chan_phase[ch])
            PH_LOW: begin
                if (len == '0) begin
                    chan_phase[ch]  = PH_HIGH;
                    res.out_channel = ch;
                    res.out_last    = 1'b1;
                    res.out_empty   = 1'b1;
                    return 1'b1;
                end
                chan_left[ch]  = len;
                chan_phase[ch] = PH_PAYLOAD;
                return 1'b0;
            end
            PH_PAYLOAD: begin
                res.out_channel = ch;
                res.out_byte    = b;
                if (chan_left[ch] <= 16'd1) begin
                    chan_left[ch]  = '0;
                    chan_phase[ch] = PH_HIGH;
                    res.out_last   = 1'b1;
                end else begin
                    chan_left[ch] = chan_left[ch] - 16'd1;
                end
                return 1'b1;
            end
            default: begin
                chan_len_hi[ch] = b;
                chan_phase[ch]  = PH_LOW;
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
                chan_phase[i] = PH_HIGH;
            end
            payload_q.delete();
        end else begin
            if (rx_mon.valid && rx_mon.ready) begin
                if (deframe_byte(rx_mon.channel, rx_mon.data_byte, want)) begin
                    payload_q.push_back(want);
                end
            end
            if (tx_mon.valid && tx_mon.ready) begin
                got.out_channel = tx_mon.out_channel;
                got.out_byte    = tx_mon.out_byte;
                got.out_last    = tx_mon.out_last;
                got.out_empty   = tx_mon.out_empty;
                if (payload_q.size() == 0) begin
                    $error("Unexpected transaction on channel %0d, byte %0h",
                           got.out_channel, got.out_byte);
                    mismatch_count++;
                end else begin
                    want = payload_q.pop_front();
                    if (got.out_channel !== want.out_channel) begin
                        $error("out_channel expected %0d, got %0d",
                               want.out_channel, got.out_channel);
                        mismatch_count++;
                    end
                    if (got.out_byte !== want.out_byte) begin
                        $error("out_byte expected %0h, got %0h",
                               want.out_byte, got.out_byte);
                        mismatch_count++;
                    end
                    if (got.out_last !== want.out_last) begin
                        $error("out_last expected %0b, got %0b",
                               want.out_last, got.out_last);
                        mismatch_count++;
                    end
                    if (got.out_empty !== want.out_empty) begin
                        $error("out_empty expected %0b, got %0b",
                               want.out_empty, got.out_empty);
                        mismatch_count++;
                    end
                end
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= payload_q.size();
    end

endmodule

>>> test/multichannel_length_prefix_deframer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Deframer testbench top
// Drives the deframer with a short directed set of messages and then with
// random interleaved messages on all channels, mixed with stray bytes. Both
// sides stall in short random bursts until the final stretch of the run.
// The checker beside the block judges every output transaction.
// ----------------------------------------------------------------------------
module multichannel_length_prefix_deframer_unit_tb;
    import mldf_pkg::*;

    localparam int RANDOM_ITEMS  = 1130;
    localparam int CALM_AFTER    = 980;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int DIRECTED_LEN  = 21;

    logic       i_clk;
    logic       i_rst_n;
    int         mismatches;
    int         outstanding;
    bit         calm;
    int         ready_hold;

    logic [1:0]        gen_phase [NUM_CHANNELS_DEF];
    logic [LEN_W-1:0]  gen_len   [NUM_CHANNELS_DEF];
    logic [LEN_W-1:0]  gen_left  [NUM_CHANNELS_DEF];

    logic [CHAN_W+BYTE_W-1:0] directed_items [DIRECTED_LEN] = '{
        {6'd0, 8'h00}, {6'd0, 8'h00},
        {6'd63, 8'h00}, {6'd63, 8'h01}, {6'd63, 8'hFF},
        {6'd1, 8'h00}, {6'd2, 8'h00}, {6'd1, 8'h03}, {6'd2, 8'h02},
        {6'd1, 8'hAA}, {6'd2, 8'h55}, {6'd1, 8'h01}, {6'd2, 8'h80},
        {6'd1, 8'h7F},
        {6'd62, 8'hFF}, {6'd62, 8'hFF}, {6'd62, 8'h00}, {6'd62, 8'hFF},
        {6'd63, 8'h01}, {6'd63, 8'h00}, {6'd63, 8'h3C}
    };

    mldf_in_if  rx_bus ();
    mldf_out_if tx_bus ();

    multichannel_length_prefix_deframer_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (rx_bus),
        .o_out   (tx_bus)
    );

    mldf_deframe_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .rx_mon        (rx_bus),
        .tx_mon        (tx_bus),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tx_bus.ready <= 1'b0;
            ready_hold   <= 0;
        end else if (ready_hold > 0) begin
            tx_bus.ready <= 1'b0;
            ready_hold   <= ready_hold - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            tx_bus.ready <= 1'b0;
            ready_hold   <= $urandom_range(0, 3);
        end else begin
            tx_bus.ready <= 1'b1;
        end
    end

    task automatic push_rx_byte(input logic [CHAN_W-1:0] ch, input logic [BYTE_W-1:0] b);
        if (!calm && $urandom_range(0, 4) == 0) begin
            rx_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        rx_bus.valid     <= 1'b1;
        rx_bus.channel   <= ch;
        rx_bus.data_byte <= b;
        do @(posedge i_clk); while (!rx_bus.ready);
    endtask

    task automatic next_stream_byte(output logic [CHAN_W-1:0] ch, output logic [BYTE_W-1:0] b);
        int               r;
        logic [LEN_W-1:0] len;
        if ($urandom_range(0, 9) < 4) begin
            ch = CHAN_W'($urandom_range(0, 3));
        end else begin
            ch = CHAN_W'($urandom_range(0, NUM_CHANNELS_DEF - 1));
        end
        b = BYTE_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 8) begin
            return;
        end
        case (gen_phase[ch])
            2'd0: begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    len = '0;
                end else if (r < 80) begin
                    len = LEN_W'($urandom_range(1, 6));
                end else if (r < 93) begin
                    len = LEN_W'($urandom_range(7, 40));
                end else if (r < 97) begin
                    len = LEN_W'($urandom_range(41, 600));
                end else begin
                    len = LEN_W'($urandom_range(0, 65535));
                end
                gen_len[ch]   = len;
                gen_phase[ch] = 2'd1;
                b             = len[15:8];
            end
            2'd1: begin
                b = gen_len[ch][7:0];
                if (gen_len[ch] == '0) begin
                    gen_phase[ch] = 2'd0;
                end else begin
                    gen_left[ch]  = gen_len[ch];
                    gen_phase[ch] = 2'd2;
                end
            end
            default: begin
                gen_left[ch] = gen_left[ch] - 16'd1;
                if (gen_left[ch] == '0) begin
                    gen_phase[ch] = 2'd0;
                end
            end
        endcase
    endtask

    initial begin
        logic [CHAN_W-1:0] ch;
        logic [BYTE_W-1:0] b;
        rx_bus.valid     <= 1'b0;
        rx_bus.channel   <= '0;
        rx_bus.data_byte <= '0;
        i_rst_n          <= 1'b0;
        calm = 1'b0;
        for (int i = 0; i < NUM_CHANNELS_DEF; i++) begin
            gen_phase[i] = 2'd0;
            gen_len[i]   = '0;
            gen_left[i]  = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_items[i]) begin
            push_rx_byte(directed_items[i][CHAN_W+BYTE_W-1:BYTE_W],
                         directed_items[i][BYTE_W-1:0]);
        end
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == CALM_AFTER) begin
                calm = 1'b1;
            end
            next_stream_byte(ch, b);
            push_rx_byte(ch, b);
        end
        rx_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
rtl/mldf_pkg.sv
rtl/mldf_if.sv
rtl/mldf_state_ram.sv
rtl/mldf_core.sv
rtl/multichannel_length_prefix_deframer_unit.sv
test/mldf_deframe_checker.sv
test/multichannel_length_prefix_deframer_unit_tb.sv
